@@ sv/chaotic_keystream_xor_cipher_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the chaotic keystream cipher
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CHAOTIC_KEYSTREAM_XOR_CIPHER_MACROS_SVH
`define CHAOTIC_KEYSTREAM_XOR_CIPHER_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is high
`define CKXC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also covers the reset cycles
`define CKXC_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CKXC_ASSERT(name, clk, rst, prop, msg)
`define CKXC_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

@@ sv/ckxc_pkg.sv @@
// ----------------------------------------------------------------------------
// ckxc_pkg
// Shared types and constants of the chaotic keystream XOR cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ckxc_pkg;

   // default configuration
   localparam int DEF_WARMUP_STEPS = 5000;
   localparam int DEF_FRAC_BITS    = 24;

   // fixed-point word and register index widths
   localparam int Q_W       = 32;
   localparam int CSR_IDX_W = 4;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEED_X = 4'd0,
      CSR_SEED_Y = 4'd1,
      CSR_SEED_Z = 4'd2,
      CSR_SEED_W = 4'd3
   } ckxc_csr_type;

   // top-level sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_OUT
   } ckxc_state_type;

   // phases of one Euler step on the shared multiplier
   typedef enum logic [2:0] {
      PH_W2,
      PH_C,
      PH_CY,
      PH_Y,
      PH_D,
      PH_E,
      PH_Z
   } ckxc_phase_type;

   // sequencer to step unit
   typedef struct packed {
      logic load;
      logic start;
   } ckxc_ctrl_type;

   // step unit to sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } ckxc_stat_type;

endpackage

@@ sv/ckxc_euler_unit.sv @@
// ----------------------------------------------------------------------------
// ckxc_euler_unit
// One Euler step of the four-variable system, built on a
// single 32x32 multiplier followed by a saturating three-input adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chaotic_keystream_xor_cipher_macros.svh"

module ckxc_euler_unit import ckxc_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ckxc_ctrl_type         ctrl,
   input  logic signed [Q_W-1:0] seed_x,
   input  logic signed [Q_W-1:0] seed_y,
   input  logic signed [Q_W-1:0] seed_z,
   input  logic signed [Q_W-1:0] seed_w,
   output ckxc_stat_type         stat,
   output logic signed [Q_W-1:0] var_x,
   output logic signed [Q_W-1:0] var_y,
   output logic signed [Q_W-1:0] var_z,
   output logic signed [Q_W-1:0] var_w
);

   // coefficients, round half up
   localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [Q_W-1:0] K_015 = Q_W'((64'sd15 * ONE + 64'sd50) / 64'sd100);
   localparam logic signed [Q_W-1:0] K_01  = Q_W'((64'sd10 * ONE + 64'sd50) / 64'sd100);
   localparam logic signed [Q_W-1:0] K_001 = Q_W'((ONE + 64'sd50) / 64'sd100);
   localparam logic signed [Q_W-1:0] K_A   = Q_W'(-((64'sd112 * ONE + 64'sd50) / 64'sd100));

   localparam logic signed [63:0] P_MAX = 64'sd2147483647;
   localparam logic signed [63:0] P_MIN = -64'sd2147483648;
   localparam logic signed [33:0] S_MAX = 34'sd2147483647;
   localparam logic signed [33:0] S_MIN = -34'sd2147483648;

   logic                  running_ff, running_in;
   ckxc_phase_type        phase_ff, phase_in;
   logic signed [Q_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in, w_ff, w_in;
   logic signed [Q_W-1:0] tmp_ff, tmp_in, e_ff, e_in;
   logic signed [63:0]    prod_ff, prod_in;

   logic signed [Q_W-1:0] mul_a, mul_b;
   logic signed [Q_W-1:0] post_a, post_b, post_c;
   logic                  post_sub;
   logic signed [63:0]    m_shr;
   logic signed [Q_W-1:0] m_sat;
   logic signed [33:0]    post_sum;
   logic signed [Q_W-1:0] post_res;
   logic                  done;

   assign done      = running_ff && (phase_ff == PH_Z);
   assign stat.busy = running_ff;
   assign stat.done = done;
   assign var_x     = x_ff;
   assign var_y     = y_ff;
   assign var_z     = z_ff;
   assign var_w     = w_ff;

   // shared multiplier, product registered
   assign prod_in = 64'(mul_a) * 64'(mul_b);

   // floor shift of the previous product, then saturate
   assign m_shr = prod_ff >>> FRAC_BITS;

   always_comb begin
      if (m_shr > P_MAX) begin
         m_sat = Q_W'(P_MAX);
      end else if (m_shr < P_MIN) begin
         m_sat = Q_W'(P_MIN);
      end else begin
         m_sat = m_shr[Q_W-1:0];
      end
   end

   // saturating a +/- b - c
   assign post_sum = 34'(post_a) + (post_sub ? -34'(post_b) : 34'(post_b)) - 34'(post_c);

   always_comb begin
      if (post_sum > S_MAX) begin
         post_res = Q_W'(S_MAX);
      end else if (post_sum < S_MIN) begin
         post_res = Q_W'(S_MIN);
      end else begin
         post_res = post_sum[Q_W-1:0];
      end
   end

   // operand routing per phase; old x is consumed before x is rewritten
   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      post_a   = '0;
      post_b   = '0;
      post_c   = '0;
      post_sub = 1'b0;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      w_in     = w_ff;
      tmp_in   = tmp_ff;
      e_in     = e_ff;
      case (phase_ff)
         PH_W2: begin
            // w*w; e = y - z - x
            mul_a    = w_ff;
            mul_b    = w_ff;
            post_a   = y_ff;
            post_b   = z_ff;
            post_sub = 1'b1;
            post_c   = x_ff;
            e_in     = post_res;
         end
         PH_C: begin
            // 0.15*z; c = -1.12 + w*w
            mul_a  = K_015;
            mul_b  = z_ff;
            post_a = K_A;
            post_b = m_sat;
            tmp_in = post_res;
         end
         PH_CY: begin
            // c*y; new x
            mul_a  = tmp_ff;
            mul_b  = y_ff;
            post_a = x_ff;
            post_b = m_sat;
            x_in   = post_res;
         end
         PH_Y: begin
            // 0.01*y; d = (z - y) - c*y
            mul_a    = K_001;
            mul_b    = y_ff;
            post_a   = z_ff;
            post_b   = m_sat;
            post_sub = 1'b1;
            post_c   = y_ff;
            tmp_in   = post_res;
         end
         PH_D: begin
            // 0.1*d; new w
            mul_a  = K_01;
            mul_b  = tmp_ff;
            post_a = w_ff;
            post_b = m_sat;
            w_in   = post_res;
         end
         PH_E: begin
            // 0.01*e; new y
            mul_a  = K_001;
            mul_b  = e_ff;
            post_a = y_ff;
            post_b = m_sat;
            y_in   = post_res;
         end
         PH_Z: begin
            // new z
            post_a = z_ff;
            post_b = m_sat;
            z_in   = post_res;
         end
         default: begin
         end
      endcase
      if (!running_ff) begin
         x_in   = ctrl.load ? seed_x : x_ff;
         y_in   = ctrl.load ? seed_y : y_ff;
         z_in   = ctrl.load ? seed_z : z_ff;
         w_in   = ctrl.load ? seed_w : w_ff;
         tmp_in = tmp_ff;
         e_in   = e_ff;
      end
   end

   // phase sequencing; a start in the last phase chains the next step
   always_comb begin
      running_in = running_ff;
      phase_in   = phase_ff;
      if (ctrl.start) begin
         running_in = 1'b1;
         phase_in   = PH_W2;
      end else if (done) begin
         running_in = 1'b0;
      end else if (running_ff) begin
         phase_in = ckxc_phase_type'(phase_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         phase_ff   <= PH_W2;
         x_ff       <= '0;
         y_ff       <= '0;
         z_ff       <= '0;
         w_ff       <= '0;
      end else begin
         running_ff <= running_in;
         phase_ff   <= phase_in;
         x_ff       <= x_in;
         y_ff       <= y_in;
         z_ff       <= z_in;
         w_ff       <= w_in;
      end
   end

   // datapath scratch
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      tmp_ff  <= tmp_in;
      e_ff    <= e_in;
   end

   `CKXC_ASSERT(a_start_free, clock, reset, ctrl.start |-> (!running_ff || done), "step started while busy")
   `CKXC_ASSERT(a_load_idle, clock, reset, ctrl.load |-> !running_ff, "seed load during a step")
   `CKXC_ASSERT(a_run_holds, clock, reset, (running_ff && phase_ff != PH_Z) |=> running_ff, "step cut short")
   `CKXC_ASSERT_ALWAYS(a_reset_stops, clock, reset |=> !running_ff, "step unit running after reset")

endmodule

@@ sv/chaotic_keystream_xor_cipher.sv @@
// ----------------------------------------------------------------------------
// chaotic_keystream_xor_cipher
// Keystream cipher from a four-variable chaotic system with Euler steps.
// ----------------------------------------------------------------------------
// One Euler step runs on the shared multiplier in ckxc_euler_unit.
// Plain request: a single Euler step, then the result goes to the output register.
// First-byte request: seeds loaded, then WARMUP_STEPS warm-up steps before that step.
// Ready drops while a request is in work; the output register frees the input.
// Synchronous active-high reset: seeds and state zero, key stream all zero.
`timescale 1ns / 1ps
`include "chaotic_keystream_xor_cipher_macros.svh"

module chaotic_keystream_xor_cipher import ckxc_pkg::*; #(
   parameter int WARMUP_STEPS = DEF_WARMUP_STEPS,
   parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] data_in
   input  logic [0:0]           req_tuser,   // [0] first_byte
   // response channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // [7:0] data_out, [15:8] key_out
   // register write port
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [Q_W-1:0]       csr_wdata
);

   localparam int CNT_W = (WARMUP_STEPS > 0) ? $clog2(WARMUP_STEPS + 1) : 1;
   localparam logic [CNT_W-1:0] WARM_LOAD = CNT_W'(WARMUP_STEPS);

   ckxc_state_type        state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [7:0]            byte_ff, byte_in;
   logic signed [Q_W-1:0] seed_x_ff, seed_y_ff, seed_z_ff, seed_w_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_data_ff, rsp_key_ff;
   logic                  rsp_load;
   logic [7:0]            key_byte;
   ckxc_ctrl_type         ctrl;
   ckxc_stat_type         stat;
   logic signed [Q_W-1:0] var_x, var_y, var_z, var_w;

   // bits 1:0 of v / 2^s truncated toward zero
   function automatic logic [1:0] key_bits(input logic signed [Q_W-1:0] v, input int s);
      logic signed [Q_W-1:0] shr;
      logic [Q_W-1:0]        mask;
      logic                  inc;
      shr  = v >>> s;
      mask = (Q_W'(1) << s) - Q_W'(1);
      inc  = v[Q_W-1] & (|(v & mask));
      return shr[1:0] + {1'b0, inc};
   endfunction

   ckxc_euler_unit #(
      .FRAC_BITS(FRAC_BITS)
   ) u_euler (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .seed_x (seed_x_ff),
      .seed_y (seed_y_ff),
      .seed_z (seed_z_ff),
      .seed_w (seed_w_ff),
      .stat   (stat),
      .var_x  (var_x),
      .var_y  (var_y),
      .var_z  (var_z),
      .var_w  (var_w)
   );

   // seed registers, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_x_ff <= '0;
         seed_y_ff <= '0;
         seed_z_ff <= '0;
         seed_w_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SEED_X: seed_x_ff <= csr_wdata;
            CSR_SEED_Y: seed_y_ff <= csr_wdata;
            CSR_SEED_Z: seed_z_ff <= csr_wdata;
            CSR_SEED_W: seed_w_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // key byte from the committed state
   assign key_byte = {key_bits(var_x, FRAC_BITS - 11), key_bits(var_y, FRAC_BITS - 10),
                      key_bits(var_z, FRAC_BITS - 12), key_bits(var_w, FRAC_BITS - 10)};

   assign req_tready = (state_ff == ST_IDLE);

   // sequencer: accept, warm-up on a first byte plus one step, then hand off the result
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      byte_in    = byte_ff;
      ctrl.load  = 1'b0;
      ctrl.start = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ctrl.start = 1'b1;
               ctrl.load  = req_tuser[0];
               cnt_in     = req_tuser[0] ? WARM_LOAD : '0;
               byte_in    = req_tdata;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            if (stat.done) begin
               if (cnt_ff != '0) begin
                  cnt_in     = cnt_ff - CNT_W'(1);
                  ctrl.start = 1'b1;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (rsp_load) begin
         rsp_data_ff <= byte_ff ^ key_byte;
         rsp_key_ff  <= key_byte;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_key_ff, rsp_data_ff};

   `CKXC_ASSERT(a_ready_idle, clock, reset, req_tready |-> !stat.busy, "ready while a step runs")
   `CKXC_ASSERT(a_accept_runs, clock, reset, (req_tvalid && req_tready) |=> stat.busy, "request accepted without a step")
   `CKXC_ASSERT(a_last_step_out, clock, reset, (stat.done && cnt_ff == '0) |=> (state_ff == ST_OUT && !stat.busy), "final step not handed off")

endmodule

@@ tb/chaotic_keystream_xor_cipher_tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for chaotic_keystream_xor_cipher
// Drives byte requests and seed writes. A fixed-point model of the chaotic
// system tracks the trajectory and predicts each key byte. Every response is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chaotic_keystream_xor_cipher_tb;
   import ckxc_pkg::*;

   localparam int WARMUP      = DEF_WARMUP_STEPS;
   localparam int FRAC        = DEF_FRAC_BITS;
   localparam int HOLD_CYCLES = 64;
   localparam int SETTLE      = 4;
   localparam int TAIL        = 20;
   localparam int RAND_FILES  = 5;
   localparam int FILE_BYTES  = 126;

   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   // coefficients: round-half-up of c * 2^FRAC
   localparam longint K_015 = ((longint'(15) <<< FRAC) + 50) / 100;
   localparam longint K_01  = ((longint'(10) <<< FRAC) + 50) / 100;
   localparam longint K_001 = ((longint'(1) <<< FRAC) + 50) / 100;
   localparam longint K_A   = -(((longint'(112) <<< FRAC) + 50) / 100);

   typedef struct packed {
      logic [7:0] key_out;
      logic [7:0] data_out;
   } cipher_out_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;
   logic [0:0]           req_tuser  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [Q_W-1:0]       csr_wdata  = '0;

   // model state: seeds and trajectory
   logic signed [Q_W-1:0] seed_x = '0, seed_y = '0, seed_z = '0, seed_w = '0;
   logic signed [Q_W-1:0] traj_x = '0, traj_y = '0, traj_z = '0, traj_w = '0;

   cipher_out_type pending_cipher_bytes[$];
   int             mismatch_count = 0;
   bit             quiet          = 1'b0;
   bit             hold_asked     = 1'b0;

   chaotic_keystream_xor_cipher #(
      .WARMUP_STEPS(WARMUP),
      .FRAC_BITS   (FRAC)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic longint sat_q(longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
   endfunction

   // exact product, floor shift, saturate
   function automatic longint mul_q(longint a, longint b);
      longint p;
      p = a * b;
      return sat_q(p >>> FRAC);
   endfunction

   // bits 1:0 of the value scaled by 2^scale, truncated toward zero
   function automatic logic [1:0] key_pair(longint v, int scale);
      longint t;
      int     s;
      s = FRAC - scale;
      if (v >= 0) t = v >>> s;
      else t = -((-v) >>> s);
      return t[1:0];
   endfunction

   // one Euler step, all updates from the old values
   function automatic void euler_advance();
      longint x, y, z, w, w2, c, d, e;
      x  = traj_x;
      y  = traj_y;
      z  = traj_z;
      w  = traj_w;
      w2 = mul_q(w, w);
      c  = sat_q(K_A + w2);
      d  = sat_q((z - y) - mul_q(c, y));
      e  = sat_q(y - z - x);
      traj_x = Q_W'(sat_q(x + mul_q(K_015, z)));
      traj_y = Q_W'(sat_q(y + mul_q(K_01, d)));
      traj_z = Q_W'(sat_q(z + mul_q(K_001, e)));
      traj_w = Q_W'(sat_q(w + mul_q(K_001, y)));
   endfunction

   function automatic cipher_out_type next_cipher_byte(logic [7:0] data, bit first);
      cipher_out_type r;
      logic [7:0]     key;
      if (first) begin
         traj_x = seed_x;
         traj_y = seed_y;
         traj_z = seed_z;
         traj_w = seed_w;
         for (int i = 0; i < (WARMUP & 13'h1FFF); i++) euler_advance();
      end
      euler_advance();
      key = {key_pair(traj_x, 11), key_pair(traj_y, 10),
             key_pair(traj_z, 12), key_pair(traj_w, 10)};
      r.key_out  = key;
      r.data_out = data ^ key;
      return r;
   endfunction

   // ------------------------------------------------------------- drivers

   // one byte request; valid is lowered only before a gap
   task automatic send_byte(logic [7:0] data, bit first);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      pending_cipher_bytes.push_back(next_cipher_byte(data, first));
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [Q_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (ckxc_csr_type'(idx))
         CSR_SEED_X: seed_x = data;
         CSR_SEED_Y: seed_y = data;
         CSR_SEED_Z: seed_z = data;
         CSR_SEED_W: seed_w = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_seeds(logic [Q_W-1:0] x, logic [Q_W-1:0] y,
                              logic [Q_W-1:0] z, logic [Q_W-1:0] w);
      write_csr(CSR_SEED_X, x);
      write_csr(CSR_SEED_Y, y);
      write_csr(CSR_SEED_Z, z);
      write_csr(CSR_SEED_W, w);
   endtask

   // stop sending and let every expected response come back
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (pending_cipher_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // ------------------------------------------------------------- checking

   function automatic void log_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want)
         log_mismatch($sformatf("%s mismatch: expected %02h, got %02h", name, want, got));
   endfunction

   // response sink: random stalls, long hold on request
   initial begin : response_sink
      int             stall_left;
      cipher_out_type got, want;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_tvalid && rsp_tready) begin
               got = rsp_tdata;
               if (pending_cipher_bytes.size() == 0) begin
                  log_mismatch($sformatf("unexpected response %04h", got));
               end else begin
                  want = pending_cipher_bytes.pop_front();
                  check_field("data_out", want.data_out, got.data_out);
                  check_field("key_out", want.key_out, got.key_out);
               end
               stall_left = quiet ? 0 : $urandom_range(0, 7);
            end
            if (hold_asked) begin
               hold_asked = 1'b0;
               stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
               rsp_tready <= 1'b0;
               stall_left--;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // no file started yet: state is all zero, key must be zero
   task automatic test_reset_keystream();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hA5, 1'b0);
   endtask

   // saturating seeds at both ends of the range
   task automatic test_seed_extremes();
      wait_drain();
      write_seeds(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      wait_drain();
      write_seeds(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
   endtask

   // new seeds only take hold at the next first byte
   task automatic test_seed_timing();
      wait_drain();
      write_seeds(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_byte(8'h3C, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h81, 1'b0);
      send_byte(8'h7E, 1'b1);
      send_byte(8'h18, 1'b0);
   endtask

   // writes beyond the register map must leave the seeds alone
   task automatic test_bad_index();
      wait_drain();
      for (int idx = CSR_SEED_W + 1; idx < (1 << CSR_IDX_W); idx++)
         write_csr(CSR_IDX_W'(idx), $urandom());
      send_byte(8'hE7, 1'b1);
      send_byte(8'h42, 1'b0);
   endtask

   // files of random bytes, each from fresh seeds
   task automatic test_random_files();
      logic [Q_W-1:0] s[4];
      for (int f = 0; f < RAND_FILES; f++) begin
         wait_drain();
         for (int i = 0; i < 4; i++) begin
            if (f == 1) s[i] = $urandom();
            else s[i] = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
         end
         write_seeds(s[0], s[1], s[2], s[3]);
         write_csr(CSR_IDX_W'($urandom_range(CSR_SEED_W + 1, (1 << CSR_IDX_W) - 1)),
                   $urandom());
         send_byte(8'($urandom_range(0, 255)), 1'b1);
         for (int b = 1; b < FILE_BYTES; b++) begin
            if (f == 2 && b == 30) hold_asked = 1'b1;
            if (f == 3) quiet = (b < 40);
            if (f == 4 && b == 60) wait_drain();
            send_byte(8'($urandom_range(0, 255)), 1'b0);
         end
         quiet = 1'b0;
      end
   endtask

   initial begin : main
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_keystream();
      test_seed_extremes();
      test_seed_timing();
      test_bad_index();
      test_random_files();
      wait_drain();
      repeat (TAIL) @(posedge clock);
      if (mismatch_count == 0 && pending_cipher_bytes.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // run limit
   initial begin : watchdog
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
